// File: src/u8jesc_pkg.sv
// Shared types, codes and helpers for the UTF-8 to ASCII JSON escaper.
// No dependencies; used by u8jesc_decode, u8jesc_emit and the top level.
`default_nettype none

package u8jesc_pkg;

    // Kind of the final part of an escape plan, after any replacement units
    localparam logic [2:0] TAIL_NONE = 3'd0;  // nothing after the replacements
    localparam logic [2:0] TAIL_LIT  = 3'd1;  // one literal character
    localparam logic [2:0] TAIL_ESC  = 3'd2;  // backslash and one character
    localparam logic [2:0] TAIL_U16  = 3'd3;  // one \uXXXX unit
    localparam logic [2:0] TAIL_PAIR = 3'd4;  // surrogate pair, two \uXXXX units

    localparam logic [6:0] CHR_BSLASH = 7'h5c;
    localparam logic [6:0] CHR_QUOTE  = 7'h22;
    localparam logic [6:0] CHR_U      = 7'h75;
    localparam logic [6:0] CHR_B      = 7'h62;
    localparam logic [6:0] CHR_T      = 7'h74;
    localparam logic [6:0] CHR_N      = 7'h6e;
    localparam logic [6:0] CHR_F      = 7'h66;
    localparam logic [6:0] CHR_R      = 7'h72;

    localparam logic [15:0] REPL_CODE = 16'hfffd;
    localparam logic [15:0] HI_SURR   = 16'hd800;
    localparam logic [15:0] LO_SURR   = 16'hdc00;
    localparam logic [20:0] PLANE1    = 21'h10000;

    localparam int unsigned CODE_W = 21;
    localparam logic [2:0] U16_LEN = 3'd6;

    // Everything the emitter needs to spell out one input byte
    typedef struct packed {
        logic [2:0]  n_rep;  // \ufffd units first
        logic [2:0]  tail;   // TAIL_* code
        logic [15:0] val_a;  // u16 value, high surrogate, or character in [6:0]
        logic [15:0] val_b;  // low surrogate
    } plan_t;

    // Lowercase hex digit for one nibble
    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] wide;
        begin
            wide = {3'b000, nib};
            hex_char = (nib < 4'd10) ? (7'h30 + wide) : (7'h57 + wide);
        end
    endfunction

endpackage

`default_nettype wire

// File: src/u8jesc_decode.sv
// UTF-8 sequence tracker: holds the pending sequence and turns each byte into
// an escape plan. Depends on u8jesc_pkg.
`default_nettype none

module u8jesc_decode (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               byte_valid,
    output logic                    byte_ready,
    input  wire logic [7:0]         in_byte,
    input  wire logic               in_eos,
    input  wire logic               plan_ready,
    output logic                    plan_valid,
    output u8jesc_pkg::plan_t       plan
);

    logic [u8jesc_pkg::CODE_W-1:0] code_reg, code_next;
    logic [1:0]                    needed_reg, needed_next;
    logic [1:0]                    taken_reg, taken_next;

    logic                          accept;
    logic [u8jesc_pkg::CODE_W-1:0] cont_code, lead_code, out_code, surr_v;
    logic [1:0]                    cont_needed, cont_taken, lead_need;
    logic                          is_cont, do_lead, src_ascii, src_code;
    logic [2:0]                    n_rep;

    assign byte_ready = plan_ready;
    assign accept     = byte_valid && plan_ready;
    assign is_cont    = (in_byte[7:6] == 2'b10);
    assign cont_code  = {code_reg[14:0], in_byte[5:0]};
    assign cont_needed = needed_reg - 2'd1;
    assign cont_taken  = taken_reg + 2'd1;
    assign surr_v      = out_code - u8jesc_pkg::PLANE1;

    always_comb begin
        lead_need = 2'd0;
        lead_code = '0;
        if (in_byte[7:5] == 3'b110) begin
            lead_need = 2'd1;
            lead_code = {16'd0, in_byte[4:0]};
        end else if (in_byte[7:4] == 4'b1110) begin
            lead_need = 2'd2;
            lead_code = {17'd0, in_byte[3:0]};
        end else if (in_byte[7:3] == 5'b11110) begin
            lead_need = 2'd3;
            lead_code = {18'd0, in_byte[2:0]};
        end
    end

    // Sequence bookkeeping and replacement count
    always_comb begin
        code_next   = code_reg;
        needed_next = needed_reg;
        taken_next  = taken_reg;
        n_rep       = 3'd0;
        src_ascii   = 1'b0;
        src_code    = 1'b0;
        out_code    = cont_code;
        do_lead     = 1'b0;

        if (needed_reg != 2'd0) begin
            if (is_cont) begin
                if (cont_needed == 2'd0) begin
                    src_code    = 1'b1;
                    code_next   = '0;
                    needed_next = 2'd0;
                    taken_next  = 2'd0;
                end else if (in_eos) begin
                    n_rep       = 3'd1 + {1'b0, cont_taken};
                    code_next   = '0;
                    needed_next = 2'd0;
                    taken_next  = 2'd0;
                end else begin
                    code_next   = cont_code;
                    needed_next = cont_needed;
                    taken_next  = cont_taken;
                end
            end else begin
                // broken sequence: replace what was taken, then retry as a lead
                n_rep       = 3'd1 + {1'b0, taken_reg};
                code_next   = '0;
                needed_next = 2'd0;
                taken_next  = 2'd0;
                do_lead     = 1'b1;
            end
        end else begin
            do_lead = 1'b1;
        end

        if (do_lead) begin
            if (!in_byte[7]) begin
                src_ascii = 1'b1;
            end else if (lead_need == 2'd0 || in_eos) begin
                n_rep       = n_rep + 3'd1;
                code_next   = '0;
                needed_next = 2'd0;
                taken_next  = 2'd0;
            end else begin
                code_next   = lead_code;
                needed_next = lead_need;
                taken_next  = 2'd0;
            end
        end
    end

    // Tail of the plan
    always_comb begin
        plan.n_rep = n_rep;
        plan.tail  = u8jesc_pkg::TAIL_NONE;
        plan.val_a = '0;
        plan.val_b = '0;
        if (src_code) begin
            if (out_code[20:16] != 5'd0) begin
                plan.tail  = u8jesc_pkg::TAIL_PAIR;
                plan.val_a = u8jesc_pkg::HI_SURR + {5'd0, surr_v[20:10]};
                plan.val_b = u8jesc_pkg::LO_SURR | {6'd0, surr_v[9:0]};
            end else begin
                plan.tail  = u8jesc_pkg::TAIL_U16;
                plan.val_a = out_code[15:0];
            end
        end else if (src_ascii) begin
            plan.tail = u8jesc_pkg::TAIL_ESC;
            case (in_byte[6:0])
                u8jesc_pkg::CHR_QUOTE:  plan.val_a = {9'd0, u8jesc_pkg::CHR_QUOTE};
                u8jesc_pkg::CHR_BSLASH: plan.val_a = {9'd0, u8jesc_pkg::CHR_BSLASH};
                7'h08:                  plan.val_a = {9'd0, u8jesc_pkg::CHR_B};
                7'h09:                  plan.val_a = {9'd0, u8jesc_pkg::CHR_T};
                7'h0a:                  plan.val_a = {9'd0, u8jesc_pkg::CHR_N};
                7'h0c:                  plan.val_a = {9'd0, u8jesc_pkg::CHR_F};
                7'h0d:                  plan.val_a = {9'd0, u8jesc_pkg::CHR_R};
                default: begin
                    plan.val_a = {9'd0, in_byte[6:0]};
                    if (in_byte[6:5] == 2'b00) begin
                        plan.tail = u8jesc_pkg::TAIL_U16;
                    end else begin
                        plan.tail = u8jesc_pkg::TAIL_LIT;
                    end
                end
            endcase
        end
    end

    assign plan_valid = accept &&
                        (n_rep != 3'd0 || plan.tail != u8jesc_pkg::TAIL_NONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_reg   <= '0;
            needed_reg <= 2'd0;
            taken_reg  <= 2'd0;
        end else if (accept) begin
            code_reg   <= code_next;
            needed_reg <= needed_next;
            taken_reg  <= taken_next;
        end
    end

endmodule

`default_nettype wire

// File: src/u8jesc_emit.sv
// Character sequencer: holds one escape plan and spells it out, one character
// per beat, into the output register. Depends on u8jesc_pkg.
`default_nettype none

module u8jesc_emit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               plan_valid,
    input  wire u8jesc_pkg::plan_t  plan,
    output logic                    plan_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [6:0]              out_char,
    output logic                    out_last
);

    u8jesc_pkg::plan_t plan_reg;
    logic              busy_reg;
    logic [2:0]        unit_reg, dig_reg;
    logic              valid_reg, last_reg;
    logic [6:0]        char_reg;

    logic              in_rep, unit_end, plan_end, advance;
    logic [2:0]        kind, unit_len, tail_units, total_units;
    logic [15:0]       value;
    logic [6:0]        char_now;

    assign in_rep = (unit_reg < plan_reg.n_rep);
    assign kind   = in_rep ? u8jesc_pkg::TAIL_U16 : plan_reg.tail;
    assign value  = in_rep ? u8jesc_pkg::REPL_CODE
                  : (unit_reg == plan_reg.n_rep) ? plan_reg.val_a : plan_reg.val_b;

    always_comb begin
        case (plan_reg.tail)
            u8jesc_pkg::TAIL_NONE: tail_units = 3'd0;
            u8jesc_pkg::TAIL_PAIR: tail_units = 3'd2;
            default:               tail_units = 3'd1;
        endcase
    end
    assign total_units = plan_reg.n_rep + tail_units;

    always_comb begin
        case (kind)
            u8jesc_pkg::TAIL_LIT: unit_len = 3'd1;
            u8jesc_pkg::TAIL_ESC: unit_len = 3'd2;
            default:              unit_len = u8jesc_pkg::U16_LEN;
        endcase
    end

    assign unit_end = (dig_reg == unit_len - 3'd1);
    assign plan_end = unit_end && (unit_reg == total_units - 3'd1);

    always_comb begin
        char_now = u8jesc_pkg::CHR_BSLASH;
        case (kind)
            u8jesc_pkg::TAIL_LIT: char_now = value[6:0];
            u8jesc_pkg::TAIL_ESC: begin
                if (dig_reg != 3'd0) begin
                    char_now = value[6:0];
                end
            end
            default: begin
                case (dig_reg)
                    3'd1:    char_now = u8jesc_pkg::CHR_U;
                    3'd2:    char_now = u8jesc_pkg::hex_char(value[15:12]);
                    3'd3:    char_now = u8jesc_pkg::hex_char(value[11:8]);
                    3'd4:    char_now = u8jesc_pkg::hex_char(value[7:4]);
                    3'd5:    char_now = u8jesc_pkg::hex_char(value[3:0]);
                    default: char_now = u8jesc_pkg::CHR_BSLASH;
                endcase
            end
        endcase
    end

    assign advance    = busy_reg && (!valid_reg || out_ready);
    assign plan_ready = !busy_reg || (advance && plan_end);

    always_ff @(posedge aclk) begin
        if (plan_valid && plan_ready) begin
            plan_reg <= plan;
        end
        if (advance) begin
            char_reg <= char_now;
            last_reg <= plan_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            unit_reg  <= 3'd0;
            dig_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            if (plan_valid && plan_ready) begin
                busy_reg <= 1'b1;
                unit_reg <= 3'd0;
                dig_reg  <= 3'd0;
            end else if (advance) begin
                if (plan_end) begin
                    busy_reg <= 1'b0;
                end else if (unit_end) begin
                    unit_reg <= unit_reg + 3'd1;
                    dig_reg  <= 3'd0;
                end else begin
                    dig_reg <= dig_reg + 3'd1;
                end
            end
            if (advance) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

// File: src/utf8_to_ascii_json_escaper.sv
// Top level of the UTF-8 to ASCII JSON string escaper.
// Depends on u8jesc_pkg, u8jesc_decode and u8jesc_emit.
//
//   channel | dir | tdata                  | tlast
//   --------+-----+------------------------+-------------------------
//   s_      | in  | [7:0] in_byte          | end_of_string
//   m_      | out | [6:0] out_char, [7] 0  | last_of_run (final char)
//
// Rate: one output character per cycle while m_tready is high. A byte that
// yields N characters holds the input until the character sequencer has spelled
// them out (1 for printable ASCII, up to 24 for a run of \ufffd replacements).
// A byte that only extends a pending sequence is taken with no beat.
// Reset: aresetn clears the pending sequence and empties both stages.
// Stalls: the output register lets the next byte be taken while a finished
// character waits for m_tready.
`default_nettype none

module utf8_to_ascii_json_escaper (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // end_of_string
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [6:0] out_char, [7] zero
    output logic            m_tlast    // last_of_run
);

    u8jesc_pkg::plan_t plan;
    logic              plan_valid;
    logic              plan_ready;
    logic [6:0]        out_char;

    // Track UTF-8 sequences and plan the escape text for each byte
    u8jesc_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_tvalid),
        .byte_ready (s_tready),
        .in_byte    (s_tdata),
        .in_eos     (s_tlast),
        .plan_ready (plan_ready),
        .plan_valid (plan_valid),
        .plan       (plan)
    );

    // Spell out the plan one beat at a time
    u8jesc_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .plan_valid (plan_valid),
        .plan       (plan),
        .plan_ready (plan_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (out_char),
        .out_last   (m_tlast)
    );

    assign m_tdata = {1'b0, out_char};

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for utf8_to_ascii_json_escaper: streams UTF-8 bytes in,
// predicts the escaped ASCII characters and checks every output beat in order.
// Needs only the RTL under src/; no files or arguments are read.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Input byte values that get a short escape, and the first printable byte
    localparam logic [7:0] ASC_BS     = 8'h08;
    localparam logic [7:0] ASC_TAB    = 8'h09;
    localparam logic [7:0] ASC_LF     = 8'h0a;
    localparam logic [7:0] ASC_FF     = 8'h0c;
    localparam logic [7:0] ASC_CR     = 8'h0d;
    localparam logic [7:0] ASC_SPACE  = 8'h20;
    localparam logic [7:0] ASC_QUOTE  = 8'h22;
    localparam logic [7:0] ASC_BSLASH = 8'h5c;

    localparam logic [15:0]  UNIT_REPL   = 16'hfffd;
    localparam logic [15:0]  UNIT_HI     = 16'hd800;
    localparam logic [15:0]  UNIT_LO     = 16'hdc00;
    localparam logic [20:0]  PLANE_ONE   = 21'h10000;
    localparam logic [127:0] HEX_ASCII   = "0123456789abcdef";

    localparam int RANDOM_BYTES = 200;
    localparam int DRAIN_CYCLES = 40;     // well past one byte's 24 characters
    localparam int N_DIR        = 28;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } esc_char_t;

    typedef struct packed {
        logic [7:0] b;
        logic       eos;
        logic       typed;   // expected text given in dir_text
    } dir_row_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    utf8_to_ascii_json_escaper DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] in_byte
        .s_tlast  (s_tlast),    // end_of_string
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [6:0] out_char, [7] zero
        .m_tlast  (m_tlast)     // last_of_run
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Decoder state mirrored by the predictor
    // ------------------------------------------------------------------
    logic [20:0] cp_acc;        // code point bits gathered so far
    logic [1:0]  cont_left;     // continuation bytes still wanted
    logic [1:0]  cont_seen;     // continuation bytes already taken

    logic [6:0]  char_buf[$];   // characters for the byte being predicted
    esc_char_t   escaped_q[$];  // characters still owed by the block

    int unsigned gap_pct;       // chance of a sender gap before a beat
    int unsigned stall_pct;     // chance of a receiver stall burst
    int unsigned bytes_sent;
    int unsigned chars_seen;
    int unsigned points_decoded;
    int unsigned repl_units;
    int unsigned fails;

    function automatic void log_failure(input string what);
        fails++;
        if (fails <= 10)
            $display("ERROR at %0t ns: %s", $time, what);
    endfunction

    function automatic logic [6:0] nibble_char(input logic [3:0] n);
        nibble_char = HEX_ASCII[8 * (15 - int'(n)) +: 7];
    endfunction

    function automatic void put(input logic [7:0] c);
        char_buf = {char_buf, c[6:0]};
    endfunction

    // \uXXXX with lowercase hex, most significant nibble first
    function automatic void put_unit(input logic [15:0] v);
        put("\\");
        put("u");
        put({1'b0, nibble_char(v[15:12])});
        put({1'b0, nibble_char(v[11:8])});
        put({1'b0, nibble_char(v[7:4])});
        put({1'b0, nibble_char(v[3:0])});
    endfunction

    function automatic void put_repl(input int n);
        repeat (n) put_unit(UNIT_REPL);
        repl_units += n;
    endfunction

    // One \uXXXX unit, or above the basic plane a surrogate pair, no range check
    function automatic void put_point(input logic [20:0] cp);
        logic [20:0] off;
        points_decoded++;
        if (cp > 21'h00ffff) begin
            off = cp - PLANE_ONE;
            put_unit(UNIT_HI + {5'd0, off[20:10]});
            put_unit(UNIT_LO + {6'd0, off[9:0]});
        end else begin
            put_unit(cp[15:0]);
        end
    endfunction

    function automatic void put_ascii(input logic [7:0] b);
        case (b)
            ASC_QUOTE:  begin put("\\"); put("\""); end
            ASC_BSLASH: begin put("\\"); put("\\"); end
            ASC_BS:     begin put("\\"); put("b"); end
            ASC_TAB:    begin put("\\"); put("t"); end
            ASC_LF:     begin put("\\"); put("n"); end
            ASC_FF:     begin put("\\"); put("f"); end
            ASC_CR:     begin put("\\"); put("r"); end
            default: begin
                if (b < ASC_SPACE)
                    put_unit({8'h00, b});
                else
                    put(b);
            end
        endcase
    endfunction

    function automatic void clear_seq();
        cp_acc    = '0;
        cont_left = '0;
        cont_seen = '0;
    endfunction

    // Open a sequence, unless the string ends on its lead
    function automatic void open_seq(input logic [1:0] need, input logic [20:0] bits,
                                     input logic eos);
        if (eos) begin
            put_repl(1);
            clear_seq();
        end else begin
            cp_acc    = bits;
            cont_left = need;
            cont_seen = '0;
        end
    endfunction

    function automatic void take_lead(input logic [7:0] b, input logic eos);
        if (!b[7])
            put_ascii(b);
        else if (b[7:5] == 3'b110)
            open_seq(2'd1, {16'd0, b[4:0]}, eos);
        else if (b[7:4] == 4'b1110)
            open_seq(2'd2, {17'd0, b[3:0]}, eos);
        else if (b[7:3] == 5'b11110)
            open_seq(2'd3, {18'd0, b[2:0]}, eos);
        else
            put_repl(1);
    endfunction

    // Work out the characters one accepted byte causes, into char_buf
    function automatic void predict_byte(input logic [7:0] b, input logic eos);
        char_buf = {};
        if (cont_left != 0) begin
            if (b[7:6] == 2'b10) begin
                cp_acc    = {cp_acc[14:0], b[5:0]};
                cont_seen = cont_seen + 2'd1;
                cont_left = cont_left - 2'd1;
                if (cont_left == 0) begin
                    put_point(cp_acc);
                    clear_seq();
                end else if (eos) begin
                    put_repl(1 + int'(cont_seen));
                    clear_seq();
                end
            end else begin
                // broken sequence: replace what was taken, then retry the byte
                put_repl(1 + int'(cont_seen));
                clear_seq();
                take_lead(b, eos);
            end
        end else begin
            take_lead(b, eos);
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: optional gap, one beat, then book the expected characters
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic eos, input bit typed,
                             input string text);
        logic [7:0] c;
        esc_char_t  item;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        predict_byte(b, eos);
        if (typed) begin
            for (int i = 0; i < text.len(); i++) begin
                c         = text[i];
                item.ch   = c[6:0];
                item.last = (i == text.len() - 1);
                escaped_q = {escaped_q, item};
            end
        end else begin
            foreach (char_buf[i]) begin
                item.ch   = char_buf[i];
                item.last = (i == char_buf.size() - 1);
                escaped_q = {escaped_q, item};
            end
        end
    endtask

    // Hold the input idle until the block owes nothing
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (escaped_q.size() != 0) @(posedge aclk);
    endtask

    // One random run: one ASCII byte, a multi-byte sequence with random payload
    // (some truncated or broken), or one raw noise byte
    task automatic send_random_run();
        logic [7:0] run_q[$];
        int         kind;
        int         len;
        int         brk;
        logic       eos_at_end;
        kind       = $urandom_range(0, 99);
        eos_at_end = ($urandom_range(0, 4) == 0);
        if (kind < 30) begin
            run_q = {run_q, 8'($urandom_range(8'h20, 8'h7f))};
        end else if (kind < 40) begin
            run_q = {run_q, 8'($urandom_range(8'h00, 8'h1f))};
        end else if (kind < 45) begin
            run_q = {run_q, (kind[0] ? ASC_QUOTE : ASC_BSLASH)};
        end else if (kind < 95) begin
            if (kind < 60)      len = 2;
            else if (kind < 75) len = 3;
            else if (kind < 88) len = 4;
            else                len = $urandom_range(2, 4);
            case (len)
                2:       run_q = {run_q, 8'hc0 | 8'($urandom_range(0, 31))};
                3:       run_q = {run_q, 8'he0 | 8'($urandom_range(0, 15))};
                default: run_q = {run_q, 8'hf0 | 8'($urandom_range(0, 7))};
            endcase
            repeat (len - 1) run_q = {run_q, 8'h80 | 8'($urandom_range(0, 63))};
            if (kind >= 88) begin
                // cut the sequence short, then end the string or break it
                while (run_q.size() > $urandom_range(1, len - 1))
                    run_q.delete(run_q.size() - 1);
                if ($urandom_range(0, 1) == 0) begin
                    eos_at_end = 1'b1;
                end else begin
                    brk = $urandom_range(0, 191);
                    run_q = {run_q, 8'(brk < 128 ? brk : brk + 64)};
                end
            end
        end else begin
            run_q = {run_q, 8'($urandom_range(0, 255))};
        end
        foreach (run_q[i])
            send_byte(run_q[i], eos_at_end && (i == run_q.size() - 1), 1'b0, "");
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready, with random bursts of stalled cycles
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(0, 10);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Output check: every beat against the oldest owed character
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        esc_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            chars_seen++;
            if (escaped_q.size() == 0) begin
                log_failure($sformatf("unexpected beat tdata=%h tlast=%b", m_tdata, m_tlast));
            end else begin
                want = escaped_q.pop_front();
                if (m_tdata !== {1'b0, want.ch} || m_tlast !== want.last)
                    log_failure($sformatf("expected tdata=%h tlast=%b, got tdata=%h tlast=%b",
                                          {1'b0, want.ch}, want.last, m_tdata, m_tlast));
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed rows: extremes, every short escape, each error path
    // ------------------------------------------------------------------
    dir_row_t dir_tab [N_DIR] = '{
        '{8'h00, 1'b0, 1'b1},   // lowest byte, control via \u00XX
        '{8'h7f, 1'b0, 1'b0},   // top of ASCII passes through
        '{8'h22, 1'b0, 1'b1},
        '{8'h5c, 1'b0, 1'b1},
        '{8'h08, 1'b0, 1'b1},
        '{8'h09, 1'b0, 1'b1},
        '{8'h0a, 1'b0, 1'b1},
        '{8'h0c, 1'b0, 1'b1},
        '{8'h0d, 1'b0, 1'b1},
        '{8'h1f, 1'b0, 1'b1},   // highest control
        '{8'hff, 1'b0, 1'b1},   // bad lead, top byte
        '{8'h80, 1'b0, 1'b1},   // stray continuation
        '{8'hc3, 1'b0, 1'b1},   // two-byte sequence, pending
        '{8'ha9, 1'b0, 1'b0},
        '{8'hf7, 1'b0, 1'b1},   // largest four-byte code, past U+10FFFF
        '{8'hbf, 1'b0, 1'b1},
        '{8'hbf, 1'b0, 1'b1},
        '{8'hbf, 1'b1, 1'b0},   // completes exactly on the string's last byte
        '{8'he2, 1'b0, 1'b1},
        '{8'h82, 1'b0, 1'b1},
        '{8'h41, 1'b0, 1'b0},   // bad continuation, byte retried as ASCII
        '{8'hf0, 1'b0, 1'b1},
        '{8'h9f, 1'b0, 1'b1},
        '{8'h98, 1'b0, 1'b1},
        '{8'h01, 1'b1, 1'b0},   // three replacements plus a control: 24 chars
        '{8'hc3, 1'b1, 1'b1},   // string ends on a lead
        '{8'he2, 1'b0, 1'b1},
        '{8'h82, 1'b1, 1'b1}    // string ends mid-sequence
    };

    string dir_text [N_DIR] = '{
        "\\u0000", "", "\\\"", "\\\\", "\\b", "\\t", "\\n", "\\f", "\\r", "\\u001f",
        "\\ufffd", "\\ufffd", "", "", "", "", "", "", "", "", "", "", "", "",
        "", "\\ufffd", "", "\\ufffd\\ufffd"
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned random_sent;
        gap_pct        = 20;
        stall_pct      = 15;
        bytes_sent     = 0;
        chars_seen     = 0;
        points_decoded = 0;
        repl_units     = 0;
        fails          = 0;
        clear_seq();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i])
            send_byte(dir_tab[i].b, dir_tab[i].eos, dir_tab[i].typed, dir_text[i]);

        // pause the sender with everything flushed before the random part
        hold_until_drained();

        // random part in phases: moderate idling, none, heavy, then none to the end
        random_sent = 0;
        while (random_sent < RANDOM_BYTES) begin
            if (random_sent < 80) begin
                gap_pct = 25; stall_pct = 20;
            end else if (random_sent < 120) begin
                gap_pct = 0;  stall_pct = 0;
            end else if (random_sent < 180) begin
                gap_pct = 50; stall_pct = 40;
            end else begin
                gap_pct = 0;  stall_pct = 0;
            end
            send_random_run();
            random_sent = bytes_sent - N_DIR;
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes (%0d directed), checked %0d output characters.",
                 bytes_sent, N_DIR, chars_seen);
        $display("Decoded %0d code points; %0d replacement units; %0d failures.",
                 points_decoded, repl_units, fails);
        if (fails == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #1_000_000;
        $display("Timeout with %0d characters still owed", escaped_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
